>>> src/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int VALUE_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 4;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_DELETE = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

>>> src/spq_ifc.sv
interface spq_req_if import spq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [COUNT_W-1:0]        count;
   logic                      top_valid;
   logic signed [VALUE_W-1:0] top_value;

   modport source (output valid, output status, output count, output top_valid,
                   output top_value, input ready);
   modport sink (input valid, input status, input count, input top_valid,
                 input top_value, output ready);
endinterface

>>> src/spq_cell.sv
module spq_cell import spq_pkg::*; (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic                      occupied,
   input  logic                      left_take,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic                      take,
   output logic                      match,
   output logic signed [VALUE_W-1:0] value_q,
   output logic signed [VALUE_W-1:0] value_next
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      greater;

   assign greater = value_ff > ctrl.value;
   assign take    = !occupied || !greater;
   assign match   = occupied && (value_ff == ctrl.value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en) begin
         if (left_take) begin
            value_in = left_value;
         end else if (take) begin
            value_in = ctrl.value;
         end
      end else if (ctrl.del_en && !greater) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q    = value_ff;
   assign value_next = value_in;

endmodule

>>> src/sorted_priority_queue_unit.sv
// Sorted priority queue of signed 32-bit values, largest at the head.
// The req channel carries one word per operation: mode selects insert or
// delete of the first entry equal to value. The rsp channel returns one
// word per operation with the status, the count after the operation and
// the current largest value (top_value is zero when the queue is empty).
// A row of DEPTH cells holds the entries; every cell compares its entry
// with the incoming value in parallel and takes its new entry from itself,
// its left neighbor, its right neighbor or the incoming value, so each
// operation completes in the cycle it is accepted.
// The response is registered: rsp valid rises in the cycle after acceptance,
// and one word per cycle is sustained while rsp is taken.
// When the receiver stalls, the response register holds its word and
// req ready drops until that word is taken; no word is lost.
// Reset empties the queue and clears rsp valid; the response data and the
// entry storage itself are not cleared and need no clearing pass.
module sorted_priority_queue_unit import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   spq_req_if.sink req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_top_valid_ff;
   logic signed [VALUE_W-1:0] rsp_top_value_ff;
   logic signed [VALUE_W-1:0] top_value_in;

   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      found;
   cell_ctrl_type             ctrl;

   logic                      take [DEPTH];
   logic [DEPTH-1:0]          match;
   logic signed [VALUE_W-1:0] value_q [DEPTH];
   logic signed [VALUE_W-1:0] value_next [DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = count_ff == CW'(DEPTH);
   assign empty        = count_ff == '0;
   assign found        = |match;

   assign ctrl.value  = req_ch.value;
   assign ctrl.ins_en = accept && (req_ch.mode == MODE_INSERT) && !full;
   assign ctrl.del_en = accept && (req_ch.mode == MODE_DELETE) && found;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      occupied;
      logic                      left_take;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      assign occupied = CW'(i) < count_ff;

      if (i == 0) begin : g_head
         assign left_take  = 1'b0;
         assign left_value = value_q[i];
      end else begin : g_body
         assign left_take  = take[i-1];
         assign left_value = value_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = value_q[i];
      end else begin : g_inner
         assign right_value = value_q[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .left_take  (left_take),
         .left_value (left_value),
         .right_value(right_value),
         .take       (take[i]),
         .match      (match[i]),
         .value_q    (value_q[i]),
         .value_next (value_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.del_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      if (req_ch.mode == MODE_INSERT) begin
         rsp_status_in = full ? STATUS_FULL : STATUS_OK;
      end else if (empty) begin
         rsp_status_in = STATUS_EMPTY;
      end else begin
         rsp_status_in = found ? STATUS_OK : STATUS_NOT_FOUND;
      end
   end

   assign top_value_in = (count_in != '0) ? value_next[0] : '0;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_count_ff     <= COUNT_W'(count_in);
         rsp_top_valid_ff <= count_in != '0;
         rsp_top_value_ff <= top_value_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.count     = rsp_count_ff;
   assign rsp_ch.top_valid = rsp_top_valid_ff;
   assign rsp_ch.top_value = rsp_top_value_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds queue depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted insert did not add one entry");

   a_refused_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_status_in != STATUS_OK) |=> $stable(count_ff))
      else $error("refused operation changed the entry count");

   for (genvar j = 0; j + 1 < DEPTH; j++) begin : g_order_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (CW'(j + 1) < count_ff) |-> (value_q[j] >= value_q[j+1]))
         else $error("stored entries are out of descending order");
   end
`endif

endmodule

>>> tb/spq_result_checker.sv
`timescale 1ns / 100ps

module spq_result_checker import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_mode,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic [COUNT_W-1:0]        rsp_count,
   input  logic                      rsp_top_valid,
   input  logic signed [VALUE_W-1:0] rsp_top_value,
   output int                        outstanding,
   output int                        fail_count
);

   typedef struct packed {
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic                      top_valid;
      logic signed [VALUE_W-1:0] top_value;
   } queue_result_type;

   logic signed [VALUE_W-1:0] model_slots [DEPTH];
   int                        model_fill;
   queue_result_type          pending_results [$];
   int                        words_checked;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s of rsp word %0d: got %0h, expected %0h",
               field, words_checked, got, want);
      fail_count++;
   endtask

   task automatic predict_queue_op(input mode_type op, input logic signed [VALUE_W-1:0] v,
                                   output queue_result_type res);
      int         pos;
      int         hit;
      status_type st;
      st = STATUS_OK;
      if (op == MODE_INSERT) begin
         if (model_fill >= DEPTH) begin
            st = STATUS_FULL;
         end else begin
            pos = model_fill;
            for (int k = 0; k < model_fill; k++) begin
               if (v >= model_slots[k]) begin
                  pos = k;
                  break;
               end
            end
            for (int k = model_fill; k > pos; k--) begin
               model_slots[k] = model_slots[k - 1];
            end
            model_slots[pos] = v;
            model_fill++;
         end
      end else begin
         if (model_fill == 0) begin
            st = STATUS_EMPTY;
         end else begin
            hit = -1;
            for (int k = 0; k < model_fill; k++) begin
               if (model_slots[k] == v) begin
                  hit = k;
                  break;
               end
            end
            if (hit < 0) begin
               st = STATUS_NOT_FOUND;
            end else begin
               for (int k = hit; k + 1 < model_fill; k++) begin
                  model_slots[k] = model_slots[k + 1];
               end
               model_fill--;
            end
         end
      end
      res.status    = st;
      res.count     = model_fill[COUNT_W-1:0];
      res.top_valid = (model_fill > 0);
      res.top_value = (model_fill > 0) ? model_slots[0] : '0;
   endtask

   always @(posedge clock) begin
      queue_result_type predicted;
      if (reset) begin
         pending_results.delete();
         model_fill    = 0;
         fail_count    = 0;
         words_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_top_value, '0);
            end else begin
               predicted = pending_results.pop_front();
               if (rsp_status !== predicted.status) begin
                  report_mismatch("status", rsp_status, predicted.status);
               end
               if (rsp_count !== predicted.count) begin
                  report_mismatch("count", rsp_count, predicted.count);
               end
               if (rsp_top_valid !== predicted.top_valid) begin
                  report_mismatch("top_valid", rsp_top_valid, predicted.top_valid);
               end
               if (rsp_top_value !== predicted.top_value) begin
                  report_mismatch("top_value", rsp_top_value, predicted.top_value);
               end
            end
            words_checked++;
         end
         if (req_valid && req_ready) begin
            predict_queue_op(mode_type'(req_mode), req_value, predicted);
            pending_results.push_back(predicted);
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench import spq_pkg::*; ;

   localparam int QUEUE_DEPTH   = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 4;
   localparam int POOL_SLOTS    = 16;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset;
   logic steady_flow;
   int   outstanding;
   int   fail_count;
   int   cycle_count = 0;
   logic signed [VALUE_W-1:0] value_pool [POOL_SLOTS];

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue_unit #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   spq_result_checker #(.DEPTH(QUEUE_DEPTH)) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_mode      (req_if.mode),
      .req_value     (req_if.value),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_status    (rsp_if.status),
      .rsp_count     (rsp_if.count),
      .rsp_top_valid (rsp_if.top_valid),
      .rsp_top_value (rsp_if.top_value),
      .outstanding   (outstanding),
      .fail_count    (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic int gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [VALUE_W-1:0] fresh_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2, 3, 4: return int'($urandom_range(0, 6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   function automatic void refill_pool();
      for (int k = 0; k < POOL_SLOTS; k++) begin
         value_pool[k] = fresh_value();
      end
   endfunction

   initial begin
      int  hold;
      logic level;
      hold  = 0;
      level = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (steady_flow) begin
            level = 1'b1;
         end else if (hold == 0) begin
            level = ($urandom_range(0, 3) != 0);
            hold  = gap_length();
         end else begin
            hold--;
         end
         rsp_if.ready <= level;
      end
   end

   task automatic send_word(input mode_type op, input logic signed [VALUE_W-1:0] v);
      int gap;
      req_if.valid <= 1'b1;
      req_if.mode  <= op;
      req_if.value <= v;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      if (!steady_flow) begin
         gap = gap_length();
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_queue();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      send_word(MODE_DELETE, 32'sd0);
      send_word(MODE_DELETE, VALUE_MIN);
      send_word(MODE_INSERT, VALUE_MAX);
      send_word(MODE_INSERT, VALUE_MIN);
      send_word(MODE_INSERT, 32'sd0);
      send_word(MODE_INSERT, -32'sd1);
      send_word(MODE_INSERT, 32'sd0);
      send_word(MODE_INSERT, VALUE_MAX);
      send_word(MODE_INSERT, 32'sd1);
      send_word(MODE_INSERT, VALUE_MIN);
      // The queue is full now, so both of these are refused.
      send_word(MODE_INSERT, 32'sd5);
      send_word(MODE_INSERT, VALUE_MAX);
      send_word(MODE_DELETE, 32'sd12345);
      send_word(MODE_DELETE, VALUE_MAX);
      send_word(MODE_DELETE, VALUE_MIN);
      send_word(MODE_DELETE, 32'sd0);
      send_word(MODE_INSERT, 32'shAAAA_AAAA);
      send_word(MODE_DELETE, 32'shAAAA_AAAA);
      send_word(MODE_DELETE, VALUE_MAX);
      send_word(MODE_DELETE, VALUE_MIN);
      send_word(MODE_DELETE, 32'sd0);
      send_word(MODE_DELETE, -32'sd1);
      send_word(MODE_DELETE, 32'sd1);
      send_word(MODE_DELETE, 32'sd1);
   endtask

   task automatic run_random_phase(input int n_items, input int insert_pct,
                                   input int pool_size);
      mode_type op;
      logic signed [VALUE_W-1:0] v;
      refill_pool();
      for (int i = 0; i < n_items; i++) begin
         if (i % 32 == 31) begin
            value_pool[$urandom_range(0, pool_size - 1)] = fresh_value();
         end
         op = ($urandom_range(1, 100) <= insert_pct) ? MODE_INSERT : MODE_DELETE;
         if ($urandom_range(0, 9) == 0) begin
            v = $urandom;
         end else begin
            v = value_pool[$urandom_range(0, pool_size - 1)];
         end
         send_word(op, v);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      steady_flow  <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_INSERT;
      req_if.value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain_queue();
      steady_flow <= 1'b1;
      run_random_phase(200, 50, 4);
      drain_queue();
      steady_flow <= 1'b0;
      run_random_phase(300, 70, 8);
      run_random_phase(300, 30, 8);
      drain_queue();
      run_random_phase(350, 55, 3);
      run_random_phase(300, 50, 16);
      drain_queue();
      run_random_phase(300, 60, 6);
      drain_queue();
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
